// File: rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
package hsv2rgb_pkg;

  localparam int unsigned NumStages = 5;

  localparam int unsigned HueW    = 10;
  localparam int unsigned PctW    = 7;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueModW = 9;
  localparam int unsigned SvW     = 14;
  localparam int unsigned FracW   = 6;
  localparam int unsigned TermW   = 20;
  localparam int unsigned SumW    = 24;
  localparam int unsigned ScaledW = 18;
  localparam int unsigned RecipW  = 19;
  localparam int unsigned ProdW   = 37;

  localparam logic [HueW-1:0]    HueWrap1   = 10'd360;
  localparam logic [HueW-1:0]    HueWrap2   = 10'd720;
  localparam logic [PctW-1:0]    PctMax     = 7'd100;
  localparam logic [TermW-1:0]   SectorSpan = 20'd60;
  localparam logic [SvW-1:0]     PctScale   = 14'd100;
  localparam logic [TermW-1:0]   TermMax    = 20'd600000;
  localparam logic [ScaledW-1:0] ScaledMax  = 18'd159375;
  localparam logic [RecipW-1:0]  RecipK     = 19'd429497;
  localparam int unsigned        RecipShift = 28;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueModW-1:0] h;
    logic [PctW-1:0]    s;
    logic [PctW-1:0]    v;
  } norm_t;

  typedef struct packed {
    logic [SvW-1:0]   sv;
    logic [PctW-1:0]  v;
    logic [FracW-1:0] f;
    sector_e          sector;
  } chroma_t;

  typedef struct packed {
    logic [ScaledW-1:0] r;
    logic [ScaledW-1:0] g;
    logic [ScaledW-1:0] b;
  } scaled_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctrl_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// Top level of the five-stage HSV to RGB converter.
//
// Input channel: in_valid_i / in_stall_o carry hue_i (degrees, wrapped modulo
// 360), saturation_i and brightness_i (percent, clamped to 100). A request is
// taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry red_o, green_o, blue_o, one
// result per request, in request order.
// Throughput: one request per cycle while the output is not stalled; the five
// register stages (wrap/clamp, sector and s*v, term products, placement and
// prescale, reciprocal multiply) each hold one request.
// Reset (rst_ni low) empties the pipeline at once; no clearing pass is needed.
// When the receiver stalls, the result holds on the outputs and each stage
// holds only if the stage after it is full, so bubbles close up and the input
// stalls only when all five stages hold a request.
module hsv_to_rgb_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]    hue_i,
  input  logic [hsv2rgb_pkg::PctW-1:0]    saturation_i,
  input  logic [hsv2rgb_pkg::PctW-1:0]    brightness_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]   red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]   green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]   blue_o
);
  import hsv2rgb_pkg::*;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] ready;
  logic [NumStages-1:0] vin;
  pipe_ctrl_t           ctrl;
  chroma_t              chroma;
  scaled_t              scaled;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    vin[0] = in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      vin[k] = valid_q[k-1];
    end
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = ready[k] ? vin[k] : valid_q[k];
      ctrl.en[k] = ready[k] && vin[k];
    end
    ctrl.vld = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NumStages-1];

  hsv2rgb_prep u_prep (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .chroma_o     (chroma)
  );

  hsv2rgb_terms u_terms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .chroma_i (chroma),
    .scaled_o (scaled)
  );

  hsv2rgb_scale u_scale_r (
    .clk_i    (clk_i),
    .en_i     (ctrl.en[NumStages-1]),
    .scaled_i (scaled.r),
    .chan_o   (red_o)
  );

  hsv2rgb_scale u_scale_g (
    .clk_i    (clk_i),
    .en_i     (ctrl.en[NumStages-1]),
    .scaled_i (scaled.g),
    .chan_o   (green_o)
  );

  hsv2rgb_scale u_scale_b (
    .clk_i    (clk_i),
    .en_i     (ctrl.en[NumStages-1]),
    .scaled_i (scaled.b),
    .chan_o   (blue_o)
  );

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request missing from first stage");

  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline full and output stalled");

  a_bubble_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-2] && !valid_q[NumStages-1]) |=> out_valid_o)
    else $error("request did not advance into empty output stage");

endmodule

// File: rtl/hsv2rgb_prep.sv
// Hue wrap, percent clamp, sector decode, hue fraction and s*v product.
module hsv2rgb_prep (
  input  logic                            clk_i,
  input  hsv2rgb_pkg::pipe_ctrl_t         ctrl_i,
  input  logic [hsv2rgb_pkg::HueW-1:0]    hue_i,
  input  logic [hsv2rgb_pkg::PctW-1:0]    saturation_i,
  input  logic [hsv2rgb_pkg::PctW-1:0]    brightness_i,
  output hsv2rgb_pkg::chroma_t            chroma_o
);
  import hsv2rgb_pkg::*;

  localparam logic [HueModW-1:0] H60  = 9'd60;
  localparam logic [HueModW-1:0] H120 = 9'd120;
  localparam logic [HueModW-1:0] H180 = 9'd180;
  localparam logic [HueModW-1:0] H240 = 9'd240;
  localparam logic [HueModW-1:0] H300 = 9'd300;
  localparam logic [PctW-1:0]    R60  = 7'd60;

  logic [HueW-1:0]    hue_red;
  norm_t              norm_d, norm_q;
  logic [HueModW-1:0] hr_wide;
  logic [PctW-1:0]    hr, hue_gap;
  chroma_t            chroma_d, chroma_q;

  always_comb begin
    if (hue_i >= HueWrap2) begin
      hue_red = hue_i - HueWrap2;
    end else if (hue_i >= HueWrap1) begin
      hue_red = hue_i - HueWrap1;
    end else begin
      hue_red = hue_i;
    end
    norm_d.h = hue_red[HueModW-1:0];
    norm_d.s = (saturation_i > PctMax) ? PctMax : saturation_i;
    norm_d.v = (brightness_i > PctMax) ? PctMax : brightness_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      norm_q <= norm_d;
    end
  end

  always_comb begin
    if (norm_q.h >= H300) begin
      chroma_d.sector = SecMagRed;
    end else if (norm_q.h >= H240) begin
      chroma_d.sector = SecBluMag;
    end else if (norm_q.h >= H180) begin
      chroma_d.sector = SecCynBlu;
    end else if (norm_q.h >= H120) begin
      chroma_d.sector = SecGrnCyn;
    end else if (norm_q.h >= H60) begin
      chroma_d.sector = SecYelGrn;
    end else begin
      chroma_d.sector = SecRedYel;
    end

    if (norm_q.h >= H240) begin
      hr_wide = norm_q.h - H240;
    end else if (norm_q.h >= H120) begin
      hr_wide = norm_q.h - H120;
    end else begin
      hr_wide = norm_q.h;
    end
    hr      = hr_wide[PctW-1:0];
    hue_gap = (hr >= R60) ? (hr - R60) : (R60 - hr);

    chroma_d.f  = FracW'(R60 - hue_gap);
    chroma_d.sv = SvW'(norm_q.s) * SvW'(norm_q.v);
    chroma_d.v  = norm_q.v;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      chroma_q <= chroma_d;
    end
  end

  assign chroma_o = chroma_q;

endmodule

// File: rtl/hsv2rgb_terms.sv
// Chroma, second component and offset terms, sector placement and channel prescale.
module hsv2rgb_terms (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsv2rgb_pkg::pipe_ctrl_t ctrl_i,
  input  hsv2rgb_pkg::chroma_t    chroma_i,
  output hsv2rgb_pkg::scaled_t    scaled_o
);
  import hsv2rgb_pkg::*;

  logic [TermW-1:0] c_d, x_d, m_d;
  logic [TermW-1:0] c_q, x_q, m_q;
  logic [SvW-1:0]   vv;
  sector_e          sector_q;
  logic [TermW-1:0] rn, gn, bn;
  logic [TermW-1:0] rt, gt, bt;
  logic [SumW-1:0]  ry, gy, by;
  scaled_t          scaled_d, scaled_q;

  always_comb begin
    vv  = SvW'(chroma_i.v) * PctScale - chroma_i.sv;
    c_d = TermW'(chroma_i.sv) * SectorSpan;
    x_d = TermW'(chroma_i.sv) * TermW'(chroma_i.f);
    m_d = TermW'(vv) * SectorSpan;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      c_q      <= c_d;
      x_q      <= x_d;
      m_q      <= m_d;
      sector_q <= chroma_i.sector;
    end
  end

  always_comb begin
    case (sector_q)
      SecRedYel: begin rn = c_q; gn = x_q; bn = '0;  end
      SecYelGrn: begin rn = x_q; gn = c_q; bn = '0;  end
      SecGrnCyn: begin rn = '0;  gn = c_q; bn = x_q; end
      SecCynBlu: begin rn = '0;  gn = x_q; bn = c_q; end
      SecBluMag: begin rn = x_q; gn = '0;  bn = c_q; end
      default:   begin rn = c_q; gn = '0;  bn = x_q; end
    endcase
    rt = rn + m_q;
    gt = gn + m_q;
    bt = bn + m_q;
    ry = {rt, 4'b0} + SumW'(rt);
    gy = {gt, 4'b0} + SumW'(gt);
    by = {bt, 4'b0} + SumW'(bt);
    scaled_d.r = ry[SumW-1:SumW-ScaledW];
    scaled_d.g = gy[SumW-1:SumW-ScaledW];
    scaled_d.b = by[SumW-1:SumW-ScaledW];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

  a_x_within_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[2] |-> x_q <= c_q)
    else $error("second component exceeds chroma");

  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[2] |-> ({1'b0, c_q} + {1'b0, m_q}) <= {1'b0, TermMax})
    else $error("chroma plus offset exceeds full scale");

  a_scaled_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[3] |-> (scaled_q.r <= ScaledMax && scaled_q.g <= ScaledMax &&
                       scaled_q.b <= ScaledMax))
    else $error("prescaled channel out of range");

endmodule

// File: rtl/hsv2rgb_scale.sv
// Final per-channel division by reciprocal multiply and output register.
module hsv2rgb_scale (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [hsv2rgb_pkg::ScaledW-1:0]   scaled_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]     chan_o
);
  import hsv2rgb_pkg::*;

  logic [ProdW-1:0] prod;
  logic [ChanW-1:0] chan_q;

  assign prod = ProdW'(scaled_i) * ProdW'(RecipK);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= prod[RecipShift+ChanW-1:RecipShift];
    end
  end

  assign chan_o = chan_q;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
`timescale 1ns / 1ps

module testbench;
  import hsv2rgb_pkg::*;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned IdlePct    = 20;
  localparam int unsigned NumRandom  = 1530;
  localparam int unsigned DrainWait  = 20;
  localparam longint unsigned RgbDen = 600000;
  localparam int unsigned FullScale  = 255;
  localparam int unsigned HueCircle  = 360;
  localparam int unsigned HueSpan    = 60;
  localparam int unsigned PctFull    = 100;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  class rgb_scoreboard;
    rgb_t        pending_rgb[$];
    int unsigned error_count;
    int unsigned request_count;
    int unsigned result_count;
    int unsigned wrapped_count;
    int unsigned clamped_count;

    function automatic logic [ChanW-1:0] scale_channel(int unsigned comp_n,
                                                       int unsigned m_n);
      longint unsigned num;
      num = longint'(FullScale) * (longint'(comp_n) + longint'(m_n));
      return ChanW'(num / RgbDen);
    endfunction

    function automatic rgb_t convert_hsv(logic [HueW-1:0] hue,
                                         logic [PctW-1:0] sat,
                                         logic [PctW-1:0] bri);
      int unsigned h, s, v, hr, hue_gap, f, sv, c_n, x_n, m_n, rn, gn, bn;
      rgb_t        rgb;
      h       = int'(hue) % HueCircle;
      s       = (sat > PctMax) ? PctFull : int'(sat);
      v       = (bri > PctMax) ? PctFull : int'(bri);
      hr      = h % (2 * HueSpan);
      hue_gap = (hr >= HueSpan) ? hr - HueSpan : HueSpan - hr;
      f       = HueSpan - hue_gap;
      sv      = s * v;
      c_n     = sv * HueSpan;
      x_n     = sv * f;
      m_n     = (PctFull * v - sv) * HueSpan;
      case (sector_e'(h / HueSpan))
        SecRedYel: begin rn = c_n; gn = x_n; bn = 0;   end
        SecYelGrn: begin rn = x_n; gn = c_n; bn = 0;   end
        SecGrnCyn: begin rn = 0;   gn = c_n; bn = x_n; end
        SecCynBlu: begin rn = 0;   gn = x_n; bn = c_n; end
        SecBluMag: begin rn = x_n; gn = 0;   bn = c_n; end
        default:   begin rn = c_n; gn = 0;   bn = x_n; end
      endcase
      rgb.red   = scale_channel(rn, m_n);
      rgb.green = scale_channel(gn, m_n);
      rgb.blue  = scale_channel(bn, m_n);
      return rgb;
    endfunction

    function void note_color(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                             logic [PctW-1:0] bri);
      request_count++;
      if (hue >= HueWrap1) wrapped_count++;
      if (sat > PctMax || bri > PctMax) clamped_count++;
      pending_rgb.push_back(convert_hsv(hue, sat, bri));
    endfunction

    function void check_rgb(rgb_t actual);
      rgb_t exp_rgb;
      result_count++;
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                 actual.red, actual.green, actual.blue);
        error_count++;
        return;
      end
      exp_rgb = pending_rgb.pop_front();
      if (actual.red !== exp_rgb.red) begin
        $display("%0t: red expected %0d actual %0d", $realtime, exp_rgb.red,
                 actual.red);
        error_count++;
      end
      if (actual.green !== exp_rgb.green) begin
        $display("%0t: green expected %0d actual %0d", $realtime, exp_rgb.green,
                 actual.green);
        error_count++;
      end
      if (actual.blue !== exp_rgb.blue) begin
        $display("%0t: blue expected %0d actual %0d", $realtime, exp_rgb.blue,
                 actual.blue);
        error_count++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [HueW-1:0]  hue_i;
  logic [PctW-1:0]  saturation_i;
  logic [PctW-1:0]  brightness_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  bit               quiet;
  rgb_scoreboard    sb;

  hsv_to_rgb_converter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i = !quiet && rst_ni && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_color(hue_i, saturation_i, brightness_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_rgb('{red: red_o, green: green_o, blue: blue_o});
    end
  end

  task automatic push_hsv(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                          logic [PctW-1:0] bri);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    hue_i        = hue;
    saturation_i = sat;
    brightness_i = bri;
    // hold the request until it is taken
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [PctW-1:0] pick_pct();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return PctW'($urandom_range(127));
    if (sel < 8) return PctW'($urandom_range(127, 95));
    return PctW'($urandom_range(3));
  endfunction

  function automatic logic [HueW-1:0] pick_hue();
    int unsigned k;
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(17) * HueSpan;
      return HueW'(k + $urandom_range(2) - 1 + (k == 0));
    end
    return HueW'($urandom_range(1023));
  endfunction

  initial begin
    sb           = new;
    quiet        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    push_hsv(10'd0,    7'd100, 7'd100);
    push_hsv(10'd1023, 7'd127, 7'd127);
    push_hsv(10'd0,    7'd0,   7'd0);
    push_hsv(10'd60,   7'd100, 7'd100);
    push_hsv(10'd120,  7'd100, 7'd100);
    push_hsv(10'd180,  7'd100, 7'd100);
    push_hsv(10'd240,  7'd100, 7'd100);
    push_hsv(10'd300,  7'd100, 7'd100);
    push_hsv(10'd359,  7'd100, 7'd100);
    push_hsv(10'd360,  7'd100, 7'd100);
    push_hsv(10'd719,  7'd80,  7'd90);
    push_hsv(10'd720,  7'd80,  7'd90);
    push_hsv(10'd30,   7'd101, 7'd50);
    push_hsv(10'd90,   7'd50,  7'd101);
    push_hsv(10'd150,  7'd77,  7'd0);
    push_hsv(10'd210,  7'd0,   7'd77);
    push_hsv(10'd270,  7'd0,   7'd127);
    push_hsv(10'd330,  7'd33,  7'd1);
    push_hsv(10'd512,  7'd1,   7'd99);
    push_hsv(10'd1000, 7'd64,  7'd63);
    push_hsv(10'd45,   7'd100, 7'd0);

    for (int i = 0; i < NumRandom; i++) begin
      quiet = (i >= 600 && i < 900);
      push_hsv(pick_hue(), pick_pct(), pick_pct());
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (sb.pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Converted %0d colors (%0d with wrapped hue, %0d with clamped percent),",
             sb.request_count, sb.wrapped_count, sb.clamped_count);
    $display("checked %0d results with random stalls on both channels.",
             sb.result_count);
    if (sb.error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_prep.sv
rtl/hsv2rgb_terms.sv
rtl/hsv2rgb_scale.sv
rtl/hsv_to_rgb_converter.sv
dv/testbench.sv
